[rtl/tsb_pkg.sv]
package tsb_pkg;

  localparam int STACK_CNT = 3;
  localparam int CNT_OUT_W = 5;
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEL_FIRST  = 2'd0,
    SEL_SECOND = 2'd1,
    SEL_THIRD  = 2'd2
  } stack_sel_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_INSERT,
    SH_REMOVE
  } shift_cmd_t;

endpackage

[rtl/tsb_cell.sv]
module tsb_cell
  import tsb_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  shift_cmd_t            cmd,
  input  logic [CW-1:0]         pos,
  input  logic [CW-1:0]         used,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] below,
  input  logic [DATA_WIDTH-1:0] above,
  output logic [DATA_WIDTH-1:0] q
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (cmd)
      SH_INSERT: begin
        if (MY_IDX == pos) begin
          q_nxt = word;
        end else if (MY_IDX > pos && MY_IDX <= used) begin
          q_nxt = below;
        end
      end
      SH_REMOVE: begin
        if (NEXT_IDX == used) begin
          q_nxt = '0;
        end else if (MY_IDX >= pos && NEXT_IDX < used) begin
          q_nxt = above;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/three_stacks_shared_buffer_core.sv]
// A word's result is registered and offered the cycle after it is accepted.
// Throughput: one word per cycle; every cell of the row shifts in the same cycle,
// so a push or pop that moves whole stacks completes in a single step.
// Input stalls only while a finished result waits on a stalled output.
// Reset (synchronous, active low) empties all three stacks and clears every cell.
module three_stacks_shared_buffer_core
  import tsb_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [1:0]         in_stack_select,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_count_first,
  output logic [4:0]         out_count_second,
  output logic [4:0]         out_count_third
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         size_r [STACK_CNT];
  logic [CW-1:0]         size_nxt [STACK_CNT];
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  logic                  acc;
  logic [CW-1:0]         used;
  logic [CW-1:0]         base;
  logic [CW-1:0]         sz;
  logic                  sel_ok;
  logic [CW-1:0]         ins_pos;
  logic [CW-1:0]         top_pos;
  logic [CW-1:0]         cell_pos;
  shift_cmd_t            cmd;
  shift_cmd_t            cell_cmd;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] top_word;
  logic [DATA_WIDTH+WORD_W-1:0] push_ext;
  logic [DATA_WIDTH+WORD_W-1:0] read_ext;
  logic [WORD_W-1:0]     read_nxt;
  status_t               status_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [WORD_W-1:0]     read_r;
  status_t               status_r;
  logic [CW+CNT_OUT_W-1:0] cnt_ext [STACK_CNT];
  logic [CNT_OUT_W-1:0]  cnt_r [STACK_CNT];

  assign acc      = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign used     = CW'(size_r[0] + size_r[1] + size_r[2]);
  assign push_ext = {{DATA_WIDTH{1'b0}}, in_push_value};
  assign word     = push_ext[DATA_WIDTH-1:0];
  assign ins_pos  = CW'(base + sz);
  assign top_pos  = CW'(base + sz - 1'b1);

  always_comb begin
    top_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == top_pos) begin
        top_word = top_word | cell_q[i];
      end
    end
  end

  assign read_ext = {{WORD_W{1'b0}}, top_word};

  always_comb begin
    sel_ok = 1'b1;
    base   = '0;
    sz     = '0;
    case (in_stack_select)
      SEL_FIRST: begin
        sz = size_r[0];
      end
      SEL_SECOND: begin
        base = size_r[0];
        sz   = size_r[1];
      end
      SEL_THIRD: begin
        base = CW'(size_r[0] + size_r[1]);
        sz   = size_r[2];
      end
      default: sel_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd        = SH_NONE;
    cell_pos   = ins_pos;
    status_nxt = ST_OK;
    read_nxt   = '0;
    for (int k = 0; k < STACK_CNT; k++) begin
      size_nxt[k] = size_r[k];
    end
    if (sel_ok) begin
      case (in_action)
        ACT_PUSH: begin
          if (used == CW'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            cmd = SH_INSERT;
            for (int k = 0; k < STACK_CNT; k++) begin
              if (in_stack_select == 2'(k)) begin
                size_nxt[k] = CW'(size_r[k] + 1'b1);
              end
            end
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (sz == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            read_nxt = read_ext[WORD_W-1:0];
            if (in_action == ACT_POP) begin
              cmd      = SH_REMOVE;
              cell_pos = top_pos;
              for (int k = 0; k < STACK_CNT; k++) begin
                if (in_stack_select == 2'(k)) begin
                  size_nxt[k] = CW'(size_r[k] - 1'b1);
                end
              end
            end
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  always_comb begin
    cell_cmd = SH_NONE;
    if (acc) begin
      cell_cmd = cmd;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] below;
    logic [DATA_WIDTH-1:0] above;
    if (g == 0) begin : g_lo
      assign below = '0;
    end else begin : g_lo
      assign below = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign above = '0;
    end else begin : g_hi
      assign above = cell_q[g+1];
    end
    tsb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .IDX        (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cell_cmd),
      .pos   (cell_pos),
      .used  (used),
      .word  (word),
      .below (below),
      .above (above),
      .q     (cell_q[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    for (int k = 0; k < STACK_CNT; k++) begin
      cnt_ext[k] = {{CNT_OUT_W{1'b0}}, size_nxt[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < STACK_CNT; k++) begin
        size_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        for (int k = 0; k < STACK_CNT; k++) begin
          size_r[k] <= size_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      read_r   <= read_nxt;
      status_r <= status_nxt;
      for (int k = 0; k < STACK_CNT; k++) begin
        cnt_r[k] <= cnt_ext[k][CNT_OUT_W-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = read_r;
  assign out_status       = status_r;
  assign out_count_first  = cnt_r[0];
  assign out_count_second = cnt_r[1];
  assign out_count_third  = cnt_r[2];

  logic [CW+1:0] used_w;
  assign used_w = (CW+2)'(size_r[0]) + (CW+2)'(size_r[1]) + (CW+2)'(size_r[2]);

  a_never_overfull: assert property (@(posedge clk) disable iff (!rst_n)
    used_w <= (CW+2)'(DEPTH))
    else $error("stacks exceed buffer depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_action == ACT_PUSH && sel_ok && used == CW'(DEPTH))
      |=> (out_status == ST_FULL && $stable(used_w)))
    else $error("push into full buffer changed state");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_action == ACT_PUSH && sel_ok && used != CW'(DEPTH))
      |=> (used_w == $past(used_w) + 1'b1 && out_status == ST_OK))
    else $error("push did not grow buffer by one");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && sel_ok && (in_action == ACT_POP || in_action == ACT_PEEK) && sz == '0)
      |=> (out_status == ST_EMPTY && out_read_value == '0 && $stable(used_w)))
    else $error("read of empty stack misbehaved");

endmodule
